/* hw/rtl/owbm_pkg.sv */
// shared types and constants for the single-wire bus master
// phase codes, timing register struct, tick count for a phase entry
// no dependencies
`default_nettype none

package owbm_pkg;

    localparam int unsigned NumRegs = 8;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 10;
    localparam int unsigned TimerW = 10;
    localparam int unsigned PhaseW = 4;

    // action codes
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_RESET = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    // register indexes
    localparam logic [CfgIdxW-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_RESET_RECOV   = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_WRITE_LOW     = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_WRITE_HOLD    = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_READ_LOW      = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_READ_SAMPLE   = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_READ_HOLD     = 3'd7;

    // phase codes
    localparam logic [PhaseW-1:0] PH_IDLE      = 4'd0;
    localparam logic [PhaseW-1:0] PH_RST_LOW   = 4'd1;
    localparam logic [PhaseW-1:0] PH_RST_WAIT  = 4'd2;
    localparam logic [PhaseW-1:0] PH_RST_RECOV = 4'd3;
    localparam logic [PhaseW-1:0] PH_WR_IDLE   = 4'd4;
    localparam logic [PhaseW-1:0] PH_WR_LOW    = 4'd5;
    localparam logic [PhaseW-1:0] PH_WR_HOLD   = 4'd6;
    localparam logic [PhaseW-1:0] PH_RD_IDLE   = 4'd7;
    localparam logic [PhaseW-1:0] PH_RD_LOW    = 4'd8;
    localparam logic [PhaseW-1:0] PH_RD_SAMPLE = 4'd9;
    localparam logic [PhaseW-1:0] PH_RD_HOLD   = 4'd10;

    localparam logic [TimerW-1:0] WRITE_IDLE_TICKS = 10'd100;

    // reset values of the timing registers
    localparam logic [9:0] RST_RESET_LOW     = 10'd500;
    localparam logic [7:0] RST_PRESENCE_WAIT = 8'd60;
    localparam logic [9:0] RST_RESET_RECOV   = 10'd240;
    localparam logic [3:0] RST_WRITE_LOW     = 4'd2;
    localparam logic [7:0] RST_WRITE_HOLD    = 8'd60;
    localparam logic [3:0] RST_READ_LOW      = 4'd1;
    localparam logic [5:0] RST_READ_SAMPLE   = 6'd5;
    localparam logic [7:0] RST_READ_HOLD     = 8'd56;

    typedef struct packed {
        logic [9:0] reset_low_us;
        logic [7:0] presence_wait_us;
        logic [9:0] reset_recovery_us;
        logic [3:0] write_low_us;
        logic [7:0] write_hold_us;
        logic [3:0] read_low_us;
        logic [5:0] read_sample_us;
        logic [7:0] read_hold_us;
    } owbm_cfg_t;

    function automatic logic [TimerW-1:0] at_least_one(input logic [TimerW-1:0] v);
        at_least_one = (v == '0) ? TimerW'(1) : v;
    endfunction

    // ticks loaded into the timer on entry to a phase
    function automatic logic [TimerW-1:0] enter_time(input logic [PhaseW-1:0] p,
                                                      input owbm_cfg_t c);
        case (p)
            PH_RST_LOW:   enter_time = at_least_one(c.reset_low_us);
            PH_RST_WAIT:  enter_time = at_least_one(TimerW'(c.presence_wait_us));
            PH_RST_RECOV: enter_time = c.reset_recovery_us;
            PH_WR_IDLE:   enter_time = WRITE_IDLE_TICKS;
            PH_WR_LOW:    enter_time = at_least_one(TimerW'(c.write_low_us));
            PH_WR_HOLD:   enter_time = at_least_one(TimerW'(c.write_hold_us));
            PH_RD_IDLE:   enter_time = TimerW'(1);
            PH_RD_LOW:    enter_time = at_least_one(TimerW'(c.read_low_us));
            PH_RD_SAMPLE: enter_time = at_least_one(TimerW'(c.read_sample_us));
            PH_RD_HOLD:   enter_time = TimerW'(c.read_hold_us);
            default:      enter_time = '0;
        endcase
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/onewire_bus_master_unit.sv */
// single-wire bus master: one item per microsecond tick, one result item each
// depends on owbm_pkg
`default_nettype none

// Usage
// Each input item on s_axis is one microsecond tick: tuser carries the action
// (tick only, bus reset, write byte, read byte), tdata the byte to write and the
// sampled line level. Each accepted item yields exactly one result item on
// m_axis with the drive request for that tick and the status after it.
// A command is started only from idle; one arriving while busy is dropped
// and flagged as rejected in its result.
// The result of an item is in the output register in the cycle after
// acceptance. Throughput is one item per cycle while the receiver takes each
// result, set by the combinational state update between the state registers
// and the output register. s_axis_tready is high while the output register is
// empty or being taken; a stalled receiver holds one result, then stops the input.
// The cfg channel writes the eight timing registers and is always ready; it
// is meant to be used only while no command is running.
// Synchronous active-low reset returns to idle, clears the state and the
// output valid flag, and loads the default timings.
module onewire_bus_master_unit
    import owbm_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // [7:0] data_byte, [8] line_level, [15:9] zero
    input  wire logic [15:0]         s_axis_tdata,
    // [1:0] action
    input  wire logic [1:0]          s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // [0] drive_low, [1] busy_res, [2] done_res, [3] presence_fail,
    // [11:4] read_data, [12] rejected, [15:13] zero
    output logic [15:0]              m_axis_tdata,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data
);

    owbm_cfg_t cfg_reg;

    logic [PhaseW-1:0] phase_reg, phase_next;
    logic [TimerW-1:0] timer_reg, timer_next;
    logic [2:0]        bit_reg, bit_next;
    logic [7:0]        shift_reg, shift_next;
    logic [7:0]        rdres_reg, rdres_next;
    logic              nopres_reg, nopres_next;
    logic              m_valid_reg;
    logic [15:0]       m_data_reg, m_data_next;

    logic       in_acc;
    logic [1:0] action;
    logic [7:0] data_byte;
    logic       line_level;
    logic       drive, done, rejected, finish;

    assign action     = s_axis_tuser;
    assign data_byte  = s_axis_tdata[7:0];
    assign line_level = s_axis_tdata[8];

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reset_low_us      <= RST_RESET_LOW;
            cfg_reg.presence_wait_us  <= RST_PRESENCE_WAIT;
            cfg_reg.reset_recovery_us <= RST_RESET_RECOV;
            cfg_reg.write_low_us      <= RST_WRITE_LOW;
            cfg_reg.write_hold_us     <= RST_WRITE_HOLD;
            cfg_reg.read_low_us       <= RST_READ_LOW;
            cfg_reg.read_sample_us    <= RST_READ_SAMPLE;
            cfg_reg.read_hold_us      <= RST_READ_HOLD;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_RESET_LOW:     cfg_reg.reset_low_us      <= cfg_data;
                REG_PRESENCE_WAIT: cfg_reg.presence_wait_us  <= cfg_data[7:0];
                REG_RESET_RECOV:   cfg_reg.reset_recovery_us <= cfg_data;
                REG_WRITE_LOW:     cfg_reg.write_low_us      <= cfg_data[3:0];
                REG_WRITE_HOLD:    cfg_reg.write_hold_us     <= cfg_data[7:0];
                REG_READ_LOW:      cfg_reg.read_low_us       <= cfg_data[3:0];
                REG_READ_SAMPLE:   cfg_reg.read_sample_us    <= cfg_data[5:0];
                REG_READ_HOLD:     cfg_reg.read_hold_us      <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    // one tick of the bus sequencer
    always_comb begin
        phase_next  = phase_reg;
        timer_next  = timer_reg;
        bit_next    = bit_reg;
        shift_next  = shift_reg;
        rdres_next  = rdres_reg;
        nopres_next = nopres_reg;
        drive       = 1'b0;
        done        = 1'b0;
        rejected    = 1'b0;
        finish      = 1'b0;

        if (action != ACT_TICK) begin
            if (phase_reg != PH_IDLE) begin
                rejected = 1'b1;
            end else begin
                bit_next = '0;
                case (action)
                    ACT_RESET: begin
                        phase_next = PH_RST_LOW;
                    end
                    ACT_WRITE: begin
                        shift_next = data_byte;
                        phase_next = PH_WR_IDLE;
                    end
                    default: begin
                        shift_next = '0;
                        phase_next = PH_RD_IDLE;
                    end
                endcase
                timer_next = enter_time(phase_next, cfg_reg);
            end
        end

        if (phase_next != PH_IDLE) begin
            if (phase_next inside {PH_RST_LOW, PH_WR_LOW, PH_RD_LOW})
                drive = 1'b1;
            else if (phase_next == PH_WR_HOLD && !shift_next[0])
                drive = 1'b1;

            if (timer_next != '0)
                timer_next = timer_next - TimerW'(1);

            if (timer_next == '0) begin
                case (phase_next)
                    PH_RST_LOW: begin
                        phase_next = PH_RST_WAIT;
                    end
                    PH_RST_WAIT: begin
                        if (line_level) begin
                            nopres_next = 1'b1;
                            finish      = 1'b1;
                        end else begin
                            nopres_next = 1'b0;
                            if (cfg_reg.reset_recovery_us == '0)
                                finish = 1'b1;
                            else
                                phase_next = PH_RST_RECOV;
                        end
                    end
                    PH_WR_IDLE: phase_next = PH_WR_LOW;
                    PH_WR_LOW:  phase_next = PH_WR_HOLD;
                    PH_WR_HOLD: begin
                        shift_next = {1'b0, shift_next[7:1]};
                        if (bit_next == 3'd7) begin
                            finish = 1'b1;
                        end else begin
                            bit_next   = bit_next + 3'd1;
                            phase_next = PH_WR_LOW;
                        end
                    end
                    PH_RD_IDLE: phase_next = PH_RD_LOW;
                    PH_RD_LOW:  phase_next = PH_RD_SAMPLE;
                    PH_RD_SAMPLE, PH_RD_HOLD: begin
                        if (phase_next == PH_RD_SAMPLE)
                            shift_next = {line_level, shift_next[7:1]};
                        if (phase_next == PH_RD_SAMPLE && cfg_reg.read_hold_us != '0) begin
                            phase_next = PH_RD_HOLD;
                        end else if (bit_next == 3'd7) begin
                            // slot ends the byte
                            rdres_next = shift_next;
                            finish     = 1'b1;
                        end else begin
                            bit_next   = bit_next + 3'd1;
                            phase_next = PH_RD_IDLE;
                        end
                    end
                    default: finish = 1'b1;
                endcase
                if (!finish)
                    timer_next = enter_time(phase_next, cfg_reg);
            end

            if (finish) begin
                phase_next = PH_IDLE;
                timer_next = '0;
                done       = 1'b1;
            end
        end

        m_data_next = {3'b000, rejected, rdres_next, nopres_next, done,
                       (phase_next != PH_IDLE), drive};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            timer_reg   <= '0;
            bit_reg     <= '0;
            shift_reg   <= '0;
            rdres_reg   <= '0;
            nopres_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (in_acc) begin
                phase_reg  <= phase_next;
                timer_reg  <= timer_next;
                bit_reg    <= bit_next;
                shift_reg  <= shift_next;
                rdres_reg  <= rdres_next;
                nopres_reg <= nopres_next;
            end
            if (in_acc)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc)
            m_data_reg <= m_data_next;
    end

    // idle always has a cleared timer
    a_idle_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_IDLE |-> timer_reg == '0)
        else $error("timer running while idle");

    // a completed command never reports busy in the same item
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(m_axis_tdata[2] && m_axis_tdata[1]))
        else $error("done and busy together");

    // a command taken from idle leaves the block busy
    a_cmd_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && phase_reg == PH_IDLE && action != ACT_TICK
        |=> phase_reg != PH_IDLE && m_axis_tdata[1])
        else $error("command did not start");

    // a rejection only happens while a command runs
    a_reject_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && rejected |-> phase_reg != PH_IDLE)
        else $error("rejected while idle");

endmodule

`default_nettype wire

/* sim/onewire_bus_master_unit_tb.sv */
// testbench for onewire_bus_master_unit: offers one tick item per handshake, predicts
// every result item from a model of the phase sequencer and checks it field by field
// depends on owbm_pkg and onewire_bus_master_unit
module onewire_bus_master_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import owbm_pkg::*;

    typedef struct packed {
        logic       rejected;
        logic [7:0] read_data;
        logic       presence_fail;
        logic       done;
        logic       busy;
        logic       drive_low;
    } tick_status_t;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    typedef enum {LINE_LOW, LINE_HIGH, LINE_RANDOM} line_pick_t;

    class bus_master_scoreboard;
        owbm_cfg_t         timing;
        logic [PhaseW-1:0] phase;
        logic [TimerW-1:0] ticks_left;
        logic [2:0]        bit_pos;
        logic [7:0]        shifter;
        logic [7:0]        last_read;
        logic              absent;
        tick_status_t      status_q[$];
        int                errors;

        function new();
            timing = '{RST_RESET_LOW, RST_PRESENCE_WAIT, RST_RESET_RECOV, RST_WRITE_LOW,
                       RST_WRITE_HOLD, RST_READ_LOW, RST_READ_SAMPLE, RST_READ_HOLD};
            phase = PH_IDLE;
            ticks_left = '0;
            bit_pos = '0;
            shifter = '0;
            last_read = '0;
            absent = 1'b0;
            errors = 0;
        endfunction

        function void set_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
            case (idx)
                REG_RESET_LOW:     timing.reset_low_us = value[9:0];
                REG_PRESENCE_WAIT: timing.presence_wait_us = value[7:0];
                REG_RESET_RECOV:   timing.reset_recovery_us = value[9:0];
                REG_WRITE_LOW:     timing.write_low_us = value[3:0];
                REG_WRITE_HOLD:    timing.write_hold_us = value[7:0];
                REG_READ_LOW:      timing.read_low_us = value[3:0];
                REG_READ_SAMPLE:   timing.read_sample_us = value[5:0];
                REG_READ_HOLD:     timing.read_hold_us = value[7:0];
                default: ;
            endcase
        endfunction

        function logic [TimerW-1:0] min_one(logic [TimerW-1:0] v);
            return (v == '0) ? TimerW'(1) : v;
        endfunction

        function void load_phase(logic [PhaseW-1:0] p);
            phase = p;
            case (p)
                PH_RST_LOW:   ticks_left = min_one(timing.reset_low_us);
                PH_RST_WAIT:  ticks_left = min_one(TimerW'(timing.presence_wait_us));
                PH_RST_RECOV: ticks_left = timing.reset_recovery_us;
                PH_WR_IDLE:   ticks_left = WRITE_IDLE_TICKS;
                PH_WR_LOW:    ticks_left = min_one(TimerW'(timing.write_low_us));
                PH_WR_HOLD:   ticks_left = min_one(TimerW'(timing.write_hold_us));
                PH_RD_IDLE:   ticks_left = TimerW'(1);
                PH_RD_LOW:    ticks_left = min_one(TimerW'(timing.read_low_us));
                PH_RD_SAMPLE: ticks_left = min_one(TimerW'(timing.read_sample_us));
                PH_RD_HOLD:   ticks_left = TimerW'(timing.read_hold_us);
                default: begin
                    phase = PH_IDLE;
                    ticks_left = '0;
                end
            endcase
        endfunction

        // closes a read slot, true once the eighth bit is in
        function bit close_read_slot();
            if (bit_pos == 3'd7) begin
                last_read = shifter;
                return 1'b1;
            end
            bit_pos = bit_pos + 3'd1;
            load_phase(PH_RD_IDLE);
            return 1'b0;
        endfunction

        function void note_tick(logic [1:0] action, logic [7:0] data, logic line);
            tick_status_t r;
            bit ends;
            r = '0;
            ends = 1'b0;
            if (action != ACT_TICK) begin
                if (phase != PH_IDLE) begin
                    r.rejected = 1'b1;
                end else begin
                    bit_pos = '0;
                    case (action)
                        ACT_RESET: load_phase(PH_RST_LOW);
                        ACT_WRITE: begin
                            shifter = data;
                            load_phase(PH_WR_IDLE);
                        end
                        default: begin
                            shifter = '0;
                            load_phase(PH_RD_IDLE);
                        end
                    endcase
                end
            end
            if (phase != PH_IDLE) begin
                r.drive_low = (phase == PH_RST_LOW) || (phase == PH_WR_LOW) ||
                              (phase == PH_RD_LOW) || (phase == PH_WR_HOLD && !shifter[0]);
                if (ticks_left != '0)
                    ticks_left = ticks_left - TimerW'(1);
                if (ticks_left == '0) begin
                    case (phase)
                        PH_RST_LOW: load_phase(PH_RST_WAIT);
                        PH_RST_WAIT: begin
                            absent = line;
                            // no recovery wait after a missing presence pulse
                            if (line || timing.reset_recovery_us == '0)
                                ends = 1'b1;
                            else
                                load_phase(PH_RST_RECOV);
                        end
                        PH_RST_RECOV: ends = 1'b1;
                        PH_WR_IDLE:   load_phase(PH_WR_LOW);
                        PH_WR_LOW:    load_phase(PH_WR_HOLD);
                        PH_WR_HOLD: begin
                            shifter = shifter >> 1;
                            if (bit_pos == 3'd7) begin
                                ends = 1'b1;
                            end else begin
                                bit_pos = bit_pos + 3'd1;
                                load_phase(PH_WR_LOW);
                            end
                        end
                        PH_RD_IDLE: load_phase(PH_RD_LOW);
                        PH_RD_LOW:  load_phase(PH_RD_SAMPLE);
                        PH_RD_SAMPLE: begin
                            shifter = {line, shifter[7:1]};
                            if (timing.read_hold_us == '0)
                                ends = close_read_slot();
                            else
                                load_phase(PH_RD_HOLD);
                        end
                        PH_RD_HOLD: ends = close_read_slot();
                        default:    ends = 1'b1;
                    endcase
                end
                if (ends) begin
                    phase = PH_IDLE;
                    ticks_left = '0;
                    r.done = 1'b1;
                end
            end
            r.busy = (phase != PH_IDLE);
            r.presence_fail = absent;
            r.read_data = last_read;
            status_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [15:0] word);
            tick_status_t got;
            tick_status_t want;
            got = tick_status_t'(word[12:0]);
            if (status_q.size() == 0) begin
                $error("result item %0h arrived with nothing outstanding", word);
                errors++;
                return;
            end
            want = status_q.pop_front();
            compare_field("drive_low", want.drive_low, got.drive_low);
            compare_field("busy_res", want.busy, got.busy);
            compare_field("done_res", want.done, got.done);
            compare_field("presence_fail", want.presence_fail, got.presence_fail);
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("rejected", want.rejected, got.rejected);
        endfunction

        function bit is_idle();
            return phase == PH_IDLE;
        endfunction

        function int outstanding();
            return status_q.size();
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [15:0]         s_axis_tdata = '0;
    logic [1:0]          s_axis_tuser = ACT_TICK;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [15:0]         m_axis_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;

    bus_master_scoreboard book;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_off_reqs = 0;

    onewire_bus_master_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            book.check_result(m_axis_tdata);
    end

    // receiver: random stalls, plus a long hold-off whenever one is requested
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_reqs != hold_seen) begin
                hold_seen = hold_off_reqs;
                hold_left = 60;
            end
            if (hold_left > 0) begin
                m_axis_tready = 1'b0;
                hold_left--;
            end else begin
                m_axis_tready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin
        #10ms;
        $display("onewire_bus_master_unit: mismatch");
        $finish;
    end

    function void set_mode(idle_mode_t m);
        send_idle_pct = (m == IDLE_SENDER) ? 56 : (m == IDLE_BOTH) ? 6 : 0;
        stall_pct = (m == IDLE_RECEIVER) ? 56 : (m == IDLE_BOTH) ? 6 : 0;
    endfunction

    function logic pick_line(line_pick_t sel);
        return (sel == LINE_LOW) ? 1'b0 : (sel == LINE_HIGH) ? 1'b1 : 1'($urandom);
    endfunction

    function logic [1:0] random_command();
        case ($urandom_range(2))
            0:       return ACT_RESET;
            1:       return ACT_WRITE;
            default: return ACT_READ;
        endcase
    endfunction

    // entered and left at a falling edge; valid stays up unless the sender idles
    task automatic offer(input logic [1:0] action, input logic [7:0] data, input logic line);
        s_axis_tvalid = 1'b1;
        s_axis_tuser = action;
        s_axis_tdata = {7'b0, line, data};
        do @(posedge aclk); while (!s_axis_tready);
        book.note_tick(action, data, line);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge aclk);
        end
    endtask

    // issues a command and keeps ticking until it completes; meddle_pct of the
    // ticks carry a further command, which must be turned away
    task automatic run_command(input logic [1:0] action, input logic [7:0] data,
                               input line_pick_t line_sel, input int meddle_pct);
        logic [1:0] act;
        offer(action, data, pick_line(line_sel));
        while (!book.is_idle()) begin
            act = ($urandom_range(99) < meddle_pct) ? random_command() : ACT_TICK;
            offer(act, 8'($urandom), pick_line(line_sel));
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (book.outstanding() != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do @(posedge aclk); while (!cfg_ready);
        book.set_register(idx, value);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_timing(input logic [CfgDataW-1:0] rst_low, pres_wait, recov,
                              wr_low, wr_hold, rd_low, rd_sample, rd_hold);
        wait_drained();
        write_reg(REG_RESET_LOW, rst_low);
        write_reg(REG_PRESENCE_WAIT, pres_wait);
        write_reg(REG_RESET_RECOV, recov);
        write_reg(REG_WRITE_LOW, wr_low);
        write_reg(REG_WRITE_HOLD, wr_hold);
        write_reg(REG_READ_LOW, rd_low);
        write_reg(REG_READ_SAMPLE, rd_sample);
        write_reg(REG_READ_HOLD, rd_hold);
    endtask

    // bus resets and read bytes only, each with random plain ticks, possibly none, before it
    task automatic random_run(input int commands);
        int n;
        for (n = 0; n < commands; n++) begin
            while ($urandom_range(99) < 30)
                offer(ACT_TICK, 8'($urandom), 1'($urandom));
            run_command(($urandom_range(1) == 0) ? ACT_RESET : ACT_READ, 8'($urandom),
                        LINE_RANDOM, 6);
        end
    endtask

    initial begin
        int p;
        book = new();
        set_mode(IDLE_NONE);
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // plain ticks straight out of reset
        offer(ACT_TICK, 8'h00, 1'b0);
        offer(ACT_TICK, 8'hFF, 1'b1);
        offer(ACT_TICK, 8'h5A, 1'b1);

        // all zero: one-tick phases, recovery and read hold skipped; in the two bus resets
        // every busy tick carries a command, so their completion tick rejects one too
        set_timing('0, '0, '0, '0, '0, '0, '0, '0);
        run_command(ACT_RESET, 8'h00, LINE_HIGH, 100);
        run_command(ACT_RESET, 8'hFF, LINE_LOW, 100);
        run_command(ACT_WRITE, 8'h96, LINE_RANDOM, 0);
        run_command(ACT_READ, 8'h00, LINE_LOW, 0);

        // bottom of each legal range
        set_timing(10'd1, 10'd1, 10'd0, 10'd1, 10'd1, 10'd1, 10'd1, 10'd0);
        run_command(ACT_RESET, 8'h00, LINE_LOW, 0);
        run_command(ACT_READ, 8'h00, LINE_HIGH, 0);

        // upper bits set on the bus, so the narrow registers keep only their low bits
        set_mode(IDLE_BOTH);
        set_timing(10'd2, 10'h301, 10'd1, 10'h3F1, 10'h302, 10'h3F0, 10'h3C1, 10'h300);
        run_command(ACT_RESET, 8'h00, LINE_LOW, 3);
        run_command(ACT_READ, 8'h00, LINE_RANDOM, 3);

        for (p = 0; p < 4; p++) begin
            set_mode(idle_mode_t'(p));
            set_timing(CfgDataW'($urandom_range(3)), CfgDataW'($urandom_range(2)),
                       CfgDataW'($urandom_range(3)), CfgDataW'($urandom_range(15)),
                       CfgDataW'($urandom_range(10)), CfgDataW'($urandom_range(1)),
                       CfgDataW'($urandom_range(1)), CfgDataW'($urandom_range(1)));
            random_run(3);
            if (p == 0) begin
                // receiver holds off while items keep coming, then the sender waits it out
                hold_off_reqs++;
                random_run(2);
                wait_drained();
            end
        end

        wait_drained();
        repeat (4) @(posedge aclk);
        if (book.errors == 0)
            $display("onewire_bus_master_unit: match");
        else
            $display("onewire_bus_master_unit: mismatch");
        $finish;
    end

endmodule

/* onewire_bus_master_unit.f */
hw/rtl/owbm_pkg.sv
hw/rtl/onewire_bus_master_unit.sv
sim/onewire_bus_master_unit_tb.sv
